/* design/bwm_pkg.sv */
// Shared types and constants for the battery window maximum monitor.
// Depends on nothing; bwm_ifs and the top level use it.
package bwm_pkg;

	// Voltage samples and thresholds, in millivolts
	localparam int MV_W = 16;
	typedef logic [MV_W-1:0] mv_t;

	// Status codes of a result transaction
	typedef enum logic [1:0] {
		STATUS_MISREAD  = 2'd0,
		STATUS_FILLING  = 2'd1,
		STATUS_OK       = 2'd2,
		STATUS_CRITICAL = 2'd3
	} status_t;

	// Threshold after reset: 12.0 V
	localparam mv_t CRIT_MV_RESET = mv_t'(12000);

endpackage

/* design/bwm_ifs.sv */
// Valid/ready channel interfaces for sample input and status output.
// Depends on bwm_pkg for the payload types.
interface bwm_in_if;
	logic             valid;
	logic             ready;
	bwm_pkg::mv_t     sample_millivolts;

	modport source (output valid, output sample_millivolts, input ready);
	modport sink   (input valid, input sample_millivolts, output ready);
endinterface

interface bwm_out_if;
	logic              valid;
	logic              ready;
	bwm_pkg::status_t  status;
	bwm_pkg::mv_t      window_max_millivolts;

	modport source (output valid, output status, output window_max_millivolts, input ready);
	modport sink   (input valid, input status, input window_max_millivolts, output ready);
endinterface

/* design/bwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bwm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/battery_window_max_monitor_top.sv */
// Battery window maximum monitor: top level with control FSM and threshold register.
// Depends on bwm_pkg, bwm_ifs (bwm_in_if, bwm_out_if) and bwm_ram.
//
// Each sample transaction yields exactly one result transaction. A zero sample is
// reported as a misread and stores nothing. Other samples are written into a ring
// of WINDOW entries held in a one-read-port RAM; until the ring has wrapped once the
// result is "filling" with a zero maximum. After that every stored sample triggers a
// scan of the whole ring, one entry per cycle through the RAM read port, and the
// result carries the maximum and ok/critical against crit_mv_q. Misread and filling
// samples go from idle straight to emit; a scanned sample goes through scan, drain
// and emit, its length set by the single RAM read port. Emit waits for a free output
// register. A finished result waits in an output register, so the next sample is
// taken while it is pending. No clearing pass is needed after reset: the ring is
// only read once every entry has been written. The user must write the threshold
// through cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
module battery_window_max_monitor_top #(
	parameter int WINDOW = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  bwm_pkg::mv_t      cfg_wdata,
	bwm_in_if.sink            samples,
	bwm_out_if.source         results
);
	import bwm_pkg::*;

	localparam int PTR_W = $clog2(WINDOW);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t           state_q;
	mv_t              crit_mv_q;
	logic [PTR_W-1:0] wptr_q;
	logic             full_q;
	logic [PTR_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	mv_t              max_q;
	logic             res_scan_q;
	status_t          res_status_q;
	logic             out_valid_q;
	status_t          out_status_q;
	mv_t              out_max_q;

	logic             accept;
	logic             smp_zero;
	logic             ring_we;
	logic             wrap;
	mv_t              ring_rdata;
	mv_t              max_next;
	logic             out_free;
	logic             emit_fire;
	status_t          emit_status;
	mv_t              emit_max;

	// Handshake and ring write on accepted nonzero samples
	assign samples.ready = (state_q == ST_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign smp_zero      = (samples.sample_millivolts == '0);
	assign ring_we       = accept && !smp_zero;
	assign wrap          = (wptr_q == LAST_IDX);

	bwm_ram #(
		.WIDTH (MV_W),
		.DEPTH (WINDOW)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wptr_q),
		.wdata (samples.sample_millivolts),
		.raddr (rd_idx_q),
		.rdata (ring_rdata)
	);

	// Running maximum over returned read data
	assign max_next = (rd_vld_s1 && (ring_rdata > max_q)) ? ring_rdata : max_q;

	// Result selection for the emit step
	always_comb begin
		if (res_scan_q) begin
			emit_status = (max_q < crit_mv_q) ? STATUS_CRITICAL : STATUS_OK;
			emit_max    = max_q;
		end else begin
			emit_status = res_status_q;
			emit_max    = '0;
		end
	end

	assign out_free  = !out_valid_q || results.ready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_mv_q <= CRIT_MV_RESET;
		end else if (cfg_we) begin
			crit_mv_q <= cfg_wdata;
		end
	end

	// Control FSM, ring pointer, scan and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wptr_q       <= '0;
			full_q       <= 1'b0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			max_q        <= '0;
			res_scan_q   <= 1'b0;
			res_status_q <= STATUS_MISREAD;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_MISREAD;
			out_max_q    <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			// Output valid: set on emit, cleared when the pending result is taken
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						max_q    <= '0;
						rd_idx_q <= '0;
						if (smp_zero) begin
							res_scan_q   <= 1'b0;
							res_status_q <= STATUS_MISREAD;
							state_q      <= ST_EMIT;
						end else begin
							wptr_q <= wrap ? '0 : wptr_q + PTR_W'(1);
							full_q <= full_q || wrap;
							if (full_q || wrap) begin
								res_scan_q <= 1'b1;
								state_q    <= ST_SCAN;
							end else begin
								res_scan_q   <= 1'b0;
								res_status_q <= STATUS_FILLING;
								state_q      <= ST_EMIT;
							end
						end
					end
				end
				ST_SCAN: begin
					max_q <= max_next;
					if (rd_idx_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + PTR_W'(1);
					end
				end
				ST_DRAIN: begin
					max_q   <= max_next;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_status_q <= emit_status;
						out_max_q    <= emit_max;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid                 = out_valid_q;
	assign results.status                = out_status_q;
	assign results.window_max_millivolts = out_max_q;

	// Ring pointer never leaves the window
	a_wptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= LAST_IDX)
		else $error("ring write pointer out of range");

	// A zero sample leads straight to a misread result without a scan
	a_misread_path: assert property (@(posedge clk) disable iff (!arst_n)
		accept && smp_zero |=> state_q == ST_EMIT && !res_scan_q
			&& res_status_q == STATUS_MISREAD)
		else $error("misread sample did not take the direct path");

	// Read data is only accumulated in the cycle after a scan read was issued
	a_read_follow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == ST_SCAN))
		else $error("read data valid without a scan read");

	// A threshold result is only produced once the ring has filled
	a_full_before_max: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status == STATUS_OK || results.status == STATUS_CRITICAL)
			|-> full_q)
		else $error("window maximum reported before ring filled");

	// Misread and filling results carry a zero maximum
	a_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status == STATUS_MISREAD || results.status == STATUS_FILLING)
			|-> results.window_max_millivolts == '0)
		else $error("nonzero maximum on misread or filling result");

endmodule
